// ===== rtl/number_to_spoken_digit_tokens_assert.svh =====
// Assertion macros for the checker file of this block.
`ifndef NUMBER_TO_SPOKEN_DIGIT_TOKENS_ASSERT_SVH
`define NUMBER_TO_SPOKEN_DIGIT_TOKENS_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define NTSDT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define NTSDT_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ntsdt_pkg.sv =====
package ntsdt_pkg;

  // Field and port widths.
  localparam int VALUE_W     = 17;
  localparam int IN_TDATA_W  = 24;
  localparam int BYTE_W      = 8;

  // Default number of decimal places.
  localparam int MAX_DIGITS_DEF = 5;

  // Bytes per run are capped; the counter holds 0 to MAX_RESULTS.
  localparam int MAX_RESULTS = 13;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Places (counted from one at the ones digit) that carry a unit word.
  localparam int UNIT_FIRST_PLACE = 2;
  localparam int UNIT_LAST_PLACE  = 5;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

  // Division by ten: floor(v * 52429 / 2^19) is exact for every 17-bit v.
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  // Unit words, indexed by place minus two: tens, hundreds, thousands,
  // ten-thousands.
  localparam logic [15:0] UNIT_WORD [4] = '{16'hAECA, 16'hD9B0, 16'hA7C7, 16'hF2CD};

  // Which byte of a place the datapath puts out.
  typedef enum logic [1:0] {
    SEL_DIGIT   = 2'd0,
    SEL_UNIT_LO = 2'd1,
    SEL_UNIT_HI = 2'd2
  } byte_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      split;
    logic      emit;
    byte_sel_t sel;
    logic      next_pos;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic val_zero;
    logic k_zero;
    logic k_full;
    logic stop_run;
    logic has_unit;
    logic out_free;
    logic dig_last;
    logic lo_last;
    logic hi_last;
  } stat_t;

  // Largest value that fits in n decimal places, worked out at elaboration.
  function automatic logic [63:0] digit_cap(input int n);
    logic [63:0] p;
    int          i;
    p = 64'd1;
    for (i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p - 64'd1;
  endfunction

endpackage

// ===== rtl/ntsdt_datapath.sv =====
module ntsdt_datapath #(
  parameter int MAX_DIGITS = ntsdt_pkg::MAX_DIGITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [ntsdt_pkg::VALUE_W-1:0]    in_value,
  input  ntsdt_pkg::cmd_t                  cmd,
  output ntsdt_pkg::stat_t                 stat,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [ntsdt_pkg::BYTE_W-1:0]     out_byte,
  output logic                             out_last
);

  localparam int KW    = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [63:0] CAP = ntsdt_pkg::digit_cap(MAX_DIGITS);
  localparam int VW = ntsdt_pkg::VALUE_W;
  localparam int PW = VW + 16;
  localparam int DIV_SH_LO = ntsdt_pkg::DIV10_SHIFT - 16;

  logic [VW-1:0]                 value_r, value_nxt;
  logic [KW-1:0]                 k_r, k_nxt;
  logic [ntsdt_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [3:0]                    store_r [MAX_DIGITS];
  logic                          ovalid_r, ovalid_nxt;
  logic [ntsdt_pkg::BYTE_W-1:0]  obyte_r, obyte_nxt;
  logic                          olast_r, olast_nxt;

  logic [VW-1:0]                 sat_value;
  logic [PW-1:0]                 prod;
  logic [VW-DIV_SH_LO-1:0]       quot;
  logic [VW-1:0]                 rem;
  logic [KW-1:0]                 kdec;
  logic [3:0]                    cur_d;
  logic [1:0]                    uidx;
  logic [15:0]                   uword;
  logic                          rest_empty;
  logic                          cap_hit;
  int                            k_int;

  // Saturate the incoming number to the largest value that fits.
  assign sat_value = ({{(64-VW){1'b0}}, in_value} > CAP) ? CAP[VW-1:0] : in_value;

  // Divide by ten through a reciprocal multiply; the remainder is the digit.
  assign prod = {16'd0, value_r} * {{VW{1'b0}}, ntsdt_pkg::DIV10_MUL};
  assign quot = prod[PW-1:ntsdt_pkg::DIV10_SHIFT];
  assign rem  = value_r - {quot, 3'b000} - {2'b00, quot, 1'b0};

  // Current place and its digit.
  assign k_int = int'(k_r);
  assign kdec  = k_r - 1'b1;
  assign cur_d = store_r[kdec[IDX_W-1:0]];
  assign uidx  = 2'(k_int - ntsdt_pkg::UNIT_FIRST_PLACE);
  assign uword = ntsdt_pkg::UNIT_WORD[uidx];

  // Nothing is spoken after this place when it is the ones place, or the
  // tens place followed by a zero ones digit.
  assign rest_empty = (k_int == 1) || ((k_int == 2) && (store_r[0] == 4'd0));
  assign cap_hit    = (int'(cnt_r) == ntsdt_pkg::MAX_RESULTS - 1);

  always_comb begin
    stat.val_zero = (value_r == '0);
    stat.k_zero   = (k_r == '0);
    stat.k_full   = (k_int == MAX_DIGITS);
    stat.stop_run = (k_int == 1) && (cur_d == 4'd0);
    stat.has_unit = (cur_d != 4'd0) && (k_int >= ntsdt_pkg::UNIT_FIRST_PLACE) &&
                    (k_int <= ntsdt_pkg::UNIT_LAST_PLACE);
    stat.out_free = !ovalid_r || out_tready;
    stat.dig_last = cap_hit || (!stat.has_unit && rest_empty);
    stat.lo_last  = cap_hit;
    stat.hi_last  = cap_hit || rest_empty;
  end

  // Working registers: number, place counter and byte counter.
  always_comb begin
    value_nxt = value_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    if (cmd.load) begin
      value_nxt = sat_value;
      k_nxt     = '0;
      cnt_nxt   = '0;
    end else if (cmd.split) begin
      value_nxt = {{(VW - $bits(quot)){1'b0}}, quot};
      k_nxt     = k_r + 1'b1;
    end else begin
      if (cmd.emit) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      if (cmd.next_pos) begin
        k_nxt = kdec;
      end
    end
  end

  // Output register: holds a byte until the sink takes it.
  always_comb begin
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
      case (cmd.sel)
        ntsdt_pkg::SEL_DIGIT: begin
          obyte_nxt = ntsdt_pkg::ASCII_ZERO + {4'h0, cur_d};
          olast_nxt = stat.dig_last;
        end
        ntsdt_pkg::SEL_UNIT_LO: begin
          obyte_nxt = uword[7:0];
          olast_nxt = stat.lo_last;
        end
        ntsdt_pkg::SEL_UNIT_HI: begin
          obyte_nxt = uword[15:8];
          olast_nxt = stat.hi_last;
        end
        default: begin
          obyte_nxt = '0;
          olast_nxt = 1'b0;
        end
      endcase
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    k_r     <= k_nxt;
    cnt_r   <= cnt_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  // Digit store, ones digit at entry zero.
  always_ff @(posedge clk) begin
    if (cmd.split && !cmd.load) begin
      store_r[k_r[IDX_W-1:0]] <= rem[3:0];
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_byte   = obyte_r;
  assign out_last   = olast_r;

endmodule

// ===== rtl/ntsdt_ctrl.sv =====
module ntsdt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ntsdt_pkg::stat_t  stat,
  output ntsdt_pkg::cmd_t   cmd
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SPLIT   = 5'b00010,
    ST_DIGIT   = 5'b00100,
    ST_UNIT_LO = 5'b01000,
    ST_UNIT_HI = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Sequencer: split the number into digits, then walk the places downward.
  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.load     = 1'b0;
    cmd.split    = 1'b0;
    cmd.emit     = 1'b0;
    cmd.sel      = ntsdt_pkg::SEL_DIGIT;
    cmd.next_pos = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (stat.val_zero || stat.k_full) begin
          state_nxt = stat.k_zero ? ST_IDLE : ST_DIGIT;
        end else begin
          cmd.split = 1'b1;
        end
      end
      ST_DIGIT: begin
        cmd.sel = ntsdt_pkg::SEL_DIGIT;
        if (stat.stop_run) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.dig_last) begin
            state_nxt = ST_IDLE;
          end else if (stat.has_unit) begin
            state_nxt = ST_UNIT_LO;
          end else begin
            cmd.next_pos = 1'b1;
          end
        end
      end
      ST_UNIT_LO: begin
        cmd.sel = ntsdt_pkg::SEL_UNIT_LO;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.lo_last ? ST_IDLE : ST_UNIT_HI;
        end
      end
      ST_UNIT_HI: begin
        cmd.sel = ntsdt_pkg::SEL_UNIT_HI;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.hi_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.next_pos = 1'b1;
            state_nxt    = ST_DIGIT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/number_to_spoken_digit_tokens.sv =====
// Speaks an unsigned number as a byte stream for a speech module. A number
// taken on the input is saturated to 10^MAX_DIGITS - 1 and split into decimal
// digits by one shared divide-by-ten unit, one digit per cycle. The digits are
// then sent most significant first as ASCII '0'..'9'; a nonzero digit in the
// tens to ten-thousands place is followed by its two-byte unit word, low byte
// first. A zero ones digit is not sent, a value of zero sends nothing, at most
// 13 bytes go out per number, and tlast marks the final byte. A number is first
// accepted and then split into its digits; the split is then ended, and the
// bytes go out at one per cycle while the sink is ready. The next number is
// taken once the last byte of the current one is in the output register.
module number_to_spoken_digit_tokens #(
  parameter int MAX_DIGITS = ntsdt_pkg::MAX_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [16:0] value, [23:17] zero
  input  logic [ntsdt_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] token_byte
  output logic [ntsdt_pkg::BYTE_W-1:0]        out_tdata,
  output logic                                out_tlast
);

  ntsdt_pkg::cmd_t  cmd;
  ntsdt_pkg::stat_t stat;

  ntsdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ntsdt_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_tdata[ntsdt_pkg::VALUE_W-1:0]),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

// ===== rtl/ntsdt_checker.sv =====
`include "number_to_spoken_digit_tokens_assert.svh"

module ntsdt_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [ntsdt_pkg::BYTE_W-1:0]        out_tdata,
  input  logic                                out_tlast
);

  logic                            in_taken;
  logic                            out_stall;
  logic [ntsdt_pkg::BYTE_W+1:0]    out_word;
  logic                            digit_byte;
  logic                            digit_ok;

  // Handshake terms and the visible output word.
  assign in_taken   = in_tvalid && in_tready;
  assign out_stall  = out_tvalid && !out_tready;
  assign out_word   = {out_tvalid, out_tlast, out_tdata};
  assign digit_byte = out_tvalid && (out_tdata[7:4] == 4'h3);
  assign digit_ok   = (out_tdata[3:0] <= 4'd9);

  // A stalled output request keeps its byte and its end mark.
  `NTSDT_ASSERT(a_out_hold, clk, rst_n, out_stall |=> $stable(out_word), "stalled output changed")

  // A number being split blocks the next request.
  `NTSDT_ASSERT(a_busy_after_accept, clk, rst_n, in_taken |=> !in_tready, "double accept")

  // Bytes with a high nibble of 3 are real digits.
  `NTSDT_ASSERT(a_digit_range, clk, rst_n, digit_byte |-> digit_ok, "digit byte out of range")

  // Reset clears the output request.
  `NTSDT_ASSERT_RST(a_reset_out, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind number_to_spoken_digit_tokens ntsdt_checker u_ntsdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
